// ===== sv/onb_gf2m_arithmetic_unit_assert.svh =====
// Assertion macros used by the arithmetic unit back end.
`ifndef ONB_GF2M_ARITHMETIC_UNIT_ASSERT_SVH
`define ONB_GF2M_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked only out of reset.
`define ONB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define ONB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ONB_ASSERT(label, prop, msg)
`define ONB_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== sv/onbgf_pkg.sv =====
package onbgf_pkg;

    localparam int FIELD_BITS = 239;
    localparam int WORD_COUNT = 4;
    localparam int NBITS      = (FIELD_BITS < 64 * WORD_COUNT) ? FIELD_BITS : 64 * WORD_COUNT;
    localparam int PRIME      = 2 * NBITS + 1;
    localparam int OUT_WORDS  = (WORD_COUNT < 4) ? WORD_COUNT : 4;
    localparam int CNT_W      = $clog2(NBITS);
    localparam int PAD_BITS   = 64 * WORD_COUNT;

    localparam logic [2:0] OP_LOAD_A = 3'd0;
    localparam logic [2:0] OP_LOAD_B = 3'd1;
    localparam logic [2:0] OP_ADD    = 3'd2;
    localparam logic [2:0] OP_MUL    = 3'd3;
    localparam logic [2:0] OP_SQR    = 3'd4;
    localparam logic [2:0] OP_POW    = 3'd5;

    typedef logic [NBITS-1:0] t_elem;

    typedef enum logic [2:0] {
        K_LOAD_A,
        K_LOAD_B,
        K_ADD,
        K_MUL,
        K_SQR,
        K_POW
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  idx;
        logic [63:0] value;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_req;

    // 2^i +- 2^j == +-1 mod PRIME
    function automatic logic pair_hits(input int unsigned x, input int unsigned y);
        int unsigned p;
        p = PRIME;
        return ((2 * p - x - y) % PRIME == 1) || ((p - x + y) % PRIME == 1) ||
               ((x - y + p) % PRIME == 1) || ((x + y) % PRIME == 1);
    endfunction

    // Column view of the multiplication matrix: col[c][j] = mat[j][c].
    function automatic logic [NBITS-1:0][NBITS-1:0] build_cols();
        int unsigned pw [NBITS];
        int unsigned v;
        logic [NBITS-1:0][NBITS-1:0] col;
        v   = 1;
        col = '0;
        for (int i = 0; i < NBITS; i++) begin
            pw[i] = v;
            v     = (v * 2) % PRIME;
        end
        for (int i = 0; i < NBITS; i++) begin
            for (int j = 0; j < NBITS; j++) begin
                if (pair_hits(pw[i], pw[j])) begin
                    col[NBITS-1-j][NBITS-1-i] = 1'b1;
                end
            end
        end
        return col;
    endfunction

    localparam logic [NBITS-1:0][NBITS-1:0] MAT_COLS = build_cols();

    function automatic t_elem rot_left(input t_elem x);
        return {x[NBITS-2:0], x[NBITS-1]};
    endfunction

    function automatic t_elem rot_right(input t_elem x);
        return {x[0], x[NBITS-1:1]};
    endfunction

endpackage

// ===== sv/onbgf_in_if.sv =====
interface onbgf_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [1:0]  word_index;
    logic [63:0] word_value;

    modport source (output valid, output opcode, output word_index, output word_value,
                    input ready);
    modport sink   (input valid, input opcode, input word_index, input word_value,
                    output ready);
endinterface

// ===== sv/onbgf_out_if.sv =====
interface onbgf_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_word;
    logic [1:0]  result_index;
    logic        last_word;

    modport source (output valid, output result_word, output result_index,
                    output last_word, input ready);
    modport sink   (input valid, input result_word, input result_index,
                    input last_word, output ready);
endinterface

// ===== sv/onbgf_front.sv =====
// Accepts items, decodes the opcode and queues commands for the back end.
module onbgf_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    onbgf_in_if.sink           i_in,
    output onbgf_pkg::t_cmd_req o_req,
    input  logic               i_pop
);
    import onbgf_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_keep;
    logic       w_push;
    logic       w_pop;
    t_cmd       w_cmd;

    always_comb begin
        w_keep       = 1'b1;
        w_cmd.idx    = i_in.word_index;
        w_cmd.value  = i_in.word_value;
        w_cmd.kind   = K_LOAD_A;
        unique case (i_in.opcode)
            OP_LOAD_A: w_cmd.kind = K_LOAD_A;
            OP_LOAD_B: w_cmd.kind = K_LOAD_B;
            OP_ADD:    w_cmd.kind = K_ADD;
            OP_MUL:    w_cmd.kind = K_MUL;
            OP_SQR:    w_cmd.kind = K_SQR;
            OP_POW:    w_cmd.kind = K_POW;
            default:   w_keep     = 1'b0; // unused codes are dropped
        endcase
    end

    assign i_in.ready = (r_cnt != 2'd2);
    assign w_push     = i_in.valid && i_in.ready && w_keep;
    assign w_pop      = i_pop && (r_cnt != 2'd0);
    assign o_req.valid = (r_cnt != 2'd0);
    assign o_req.cmd   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

// ===== sv/onbgf_back.sv =====
// Executes queued commands: operand loads, add, square, bit-serial
// Massey-Omura multiply, square-and-multiply power; streams results.
`include "onb_gf2m_arithmetic_unit_assert.svh"
module onbgf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  onbgf_pkg::t_cmd_req i_req,
    output logic                o_pop,
    onbgf_out_if.source         o_out
);
    import onbgf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_POW_CHK,
        S_EMIT
    } t_state;

    t_state           r_state;
    t_elem            r_a, r_b, r_acc, r_base, r_e;
    t_elem            r_ra, r_rb, r_res;
    logic             r_pow;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_bit;
    logic [1:0]       r_wcnt;

    t_elem              w_tmp;
    logic               w_prod_bit;
    t_elem              w_res_next;
    logic [PAD_BITS-1:0] w_pad;
    t_elem              w_load;

    // One product bit per cycle: parity of rb & (ra x matrix).
    always_comb begin
        for (int c = 0; c < NBITS; c++) begin
            w_tmp[c] = ^(r_ra & MAT_COLS[c]);
        end
        w_prod_bit = ^(r_rb & w_tmp);
        w_res_next = {r_res[NBITS-2:0], w_prod_bit};
    end

    // Loaded word placed into the selected operand; bits past the field drop.
    always_comb begin
        w_load = (i_req.cmd.kind == K_LOAD_A) ? r_a : r_b;
        for (int b = 0; b < NBITS; b++) begin
            if (b / 64 == int'(i_req.cmd.idx)) begin
                w_load[b] = i_req.cmd.value[b % 64];
            end
        end
    end

    assign w_pad              = PAD_BITS'(r_acc);
    assign o_out.valid        = (r_state == S_EMIT);
    assign o_out.result_word  = w_pad[64 * int'(r_wcnt) +: 64];
    assign o_out.result_index = r_wcnt;
    assign o_out.last_word    = (r_wcnt == 2'(OUT_WORDS - 1));
    assign o_pop              = (r_state == S_IDLE) && i_req.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_a     <= '0;
            r_b     <= '0;
            r_acc   <= '0;
            r_base  <= '0;
            r_pow   <= 1'b0;
            r_wcnt  <= 2'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        unique case (i_req.cmd.kind)
                            K_LOAD_A: begin
                                if (32'(i_req.cmd.idx) < WORD_COUNT) r_a <= w_load;
                            end
                            K_LOAD_B: begin
                                if (32'(i_req.cmd.idx) < WORD_COUNT) r_b <= w_load;
                            end
                            K_ADD: begin
                                r_acc   <= r_a ^ r_b;
                                r_wcnt  <= 2'd0;
                                r_state <= S_EMIT;
                            end
                            K_SQR: begin
                                r_acc   <= rot_right(r_a);
                                r_wcnt  <= 2'd0;
                                r_state <= S_EMIT;
                            end
                            K_MUL: begin
                                r_ra    <= r_a;
                                r_rb    <= r_b;
                                r_res   <= '0;
                                r_cnt   <= '0;
                                r_pow   <= 1'b0;
                                r_state <= S_MUL;
                            end
                            K_POW: begin
                                r_acc   <= '1;
                                r_base  <= r_a;
                                r_e     <= r_b;
                                r_bit   <= '0;
                                r_pow   <= 1'b1;
                                r_state <= S_POW_CHK;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_MUL: begin
                    r_res <= w_res_next;
                    r_ra  <= rot_left(r_ra);
                    r_rb  <= rot_left(r_rb);
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(NBITS - 1)) begin
                        r_acc <= w_res_next;
                        if (r_pow) begin
                            r_base <= rot_right(r_base);
                            r_e    <= r_e >> 1;
                            r_bit  <= r_bit + 1'b1;
                            if (r_bit == CNT_W'(NBITS - 1)) begin
                                r_wcnt  <= 2'd0;
                                r_state <= S_EMIT;
                            end else begin
                                r_state <= S_POW_CHK;
                            end
                        end else begin
                            r_wcnt  <= 2'd0;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_POW_CHK: begin
                    if (r_e[0]) begin
                        r_ra    <= r_acc;
                        r_rb    <= r_base;
                        r_res   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_base <= rot_right(r_base);
                        r_e    <= r_e >> 1;
                        r_bit  <= r_bit + 1'b1;
                        if (r_bit == CNT_W'(NBITS - 1)) begin
                            r_wcnt  <= 2'd0;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (o_out.ready) begin
                        r_wcnt <= r_wcnt + 1'b1;
                        if (r_wcnt == 2'(OUT_WORDS - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ONB_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_out.valid, "output valid right after reset")
    `ONB_ASSERT(a_last_ends, o_out.valid && o_out.ready && o_out.last_word |=> !o_out.valid, "stream continued past last word")
    `ONB_ASSERT(a_pop_idle, o_pop |=> r_state != S_EMIT || $past(i_req.cmd.kind) == K_ADD || $past(i_req.cmd.kind) == K_SQR, "emit without a result command")
    `ONB_ASSERT(a_emit_hold, o_out.valid && !o_out.ready |=> o_out.valid && $stable(r_wcnt), "result stream dropped under stall")

endmodule

// ===== sv/onb_gf2m_arithmetic_unit.sv =====
// Input transfer to first result transfer: add and square pass the queue and then the
// issue step into the emit state; multiply passes the queue and the issue step, then
// yields its 239 product bits at one per cycle. Power: each bit of B costs one check,
// and a set bit also a full multiply. Each result then leaves as 4 words, one per cycle
// while the receiver is ready. The 2-entry queue takes new items while the executor works.
// Reset (synchronous, active low) clears A, B, accumulator, power base and the queue.
module onb_gf2m_arithmetic_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    onbgf_in_if.sink    i_in,
    onbgf_out_if.source o_out
);
    import onbgf_pkg::*;

    // Front end: accept each transfer, decode the opcode, queue the command.
    // Unused opcodes are accepted and dropped here.
    t_cmd_req w_req;
    logic     w_pop;

    onbgf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_req   (w_req),
        .i_pop   (w_pop)
    );

    // Back end: owns the operand and result state and runs one command at a
    // time; results leave as a transfer per word, least significant first.
    onbgf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

// ===== sim/onbgf_result_checker.sv =====
module onbgf_result_checker
    import onbgf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    onbgf_in_if   i_cmd,
    onbgf_out_if  i_res,
    output int    o_fail_count,
    output int    o_words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [63:0] word;
        logic [1:0]  index;
        logic        last;
    } t_word_due;

    t_word_due   words_due[$];
    t_elem       mat_row [NBITS];
    logic [255:0] op_a, op_b;
    t_elem       acc;

    assign o_words_due = words_due.size();

    function automatic t_elem spin_left(input t_elem x);
        return {x[NBITS-2:0], x[NBITS-1]};
    endfunction

    function automatic t_elem spin_right(input t_elem x);
        return {x[0], x[NBITS-1:1]};
    endfunction

    // Bit-serial Massey-Omura product, MSB first.
    function automatic t_elem onb_mul(input t_elem a, input t_elem b);
        t_elem ra, rb, prod, lin;
        ra   = a;
        rb   = b;
        prod = '0;
        for (int i = 0; i < NBITS; i++) begin
            lin = '0;
            for (int j = 0; j < NBITS; j++) begin
                if (ra[j]) lin ^= mat_row[j];
            end
            prod[NBITS-1-i] = ^(rb & lin);
            ra = spin_left(ra);
            rb = spin_left(rb);
        end
        return prod;
    endfunction

    function automatic t_elem onb_pow(input t_elem base, input t_elem ex);
        t_elem r, sq;
        r  = '1;
        sq = base;
        for (int i = 0; i < NBITS; i++) begin
            if (ex[i]) r = onb_mul(r, sq);
            sq = spin_right(sq);
        end
        return r;
    endfunction

    initial begin
        int unsigned pw [NBITS];
        int unsigned v, s, d, p;
        p = PRIME;
        v = 1;
        for (int i = 0; i < NBITS; i++) begin
            pw[i] = v;
            v = (v * 2) % p;
        end
        for (int i = 0; i < NBITS; i++) begin
            mat_row[i] = '0;
        end
        for (int i = 0; i < NBITS; i++) begin
            for (int j = 0; j < NBITS; j++) begin
                s = (pw[i] + pw[j]) % p;
                d = (pw[i] + p - pw[j]) % p;
                if (s == 1 || s == p - 1 || d == 1 || d == p - 1)
                    mat_row[NBITS-1-i][NBITS-1-j] = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_word_due w;
        logic      compute;
        if (!i_rst_n) begin
            op_a <= '0;
            op_b <= '0;
            acc  <= '0;
            o_fail_count <= 0;
            words_due.delete();
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                compute = 1'b1;
                case (i_cmd.opcode)
                    OP_LOAD_A: begin
                        op_a[64*i_cmd.word_index +: 64] = i_cmd.word_value;
                        op_a[255:NBITS] = '0;
                        compute = 1'b0;
                    end
                    OP_LOAD_B: begin
                        op_b[64*i_cmd.word_index +: 64] = i_cmd.word_value;
                        op_b[255:NBITS] = '0;
                        compute = 1'b0;
                    end
                    OP_ADD: acc = op_a[NBITS-1:0] ^ op_b[NBITS-1:0];
                    OP_MUL: acc = onb_mul(op_a[NBITS-1:0], op_b[NBITS-1:0]);
                    OP_SQR: acc = spin_right(op_a[NBITS-1:0]);
                    OP_POW: acc = onb_pow(op_a[NBITS-1:0], op_b[NBITS-1:0]);
                    default: compute = 1'b0;
                endcase
                if (compute) begin
                    for (int k = 0; k < OUT_WORDS; k++) begin
                        w.word  = 64'(256'(acc) >> (64 * k));
                        w.index = k[1:0];
                        w.last  = (k == OUT_WORDS - 1);
                        words_due.push_back(w);
                    end
                end
            end
            if (i_res.valid && i_res.ready) begin
                if (words_due.size() == 0) begin
                    $display("%0t: result word %h idx %0d with nothing expected",
                             $time, i_res.result_word, i_res.result_index);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    w = words_due.pop_front();
                    if (i_res.result_word !== w.word || i_res.result_index !== w.index ||
                        i_res.last_word !== w.last) begin
                        $display("%0t: mismatch exp word %h idx %0d last %0d, got %h %0d %0d",
                                 $time, w.word, w.index, w.last, i_res.result_word,
                                 i_res.result_index, i_res.last_word);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import onbgf_pkg::*;

    // Opcodes the unit must swallow without producing any result.
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   words_due;
    int   idle_pct;
    int   stall_pct;
    int   sent;

    onbgf_in_if  cmd_if ();
    onbgf_out_if res_if ();

    onb_gf2m_arithmetic_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if.sink),
        .o_out   (res_if.source)
    );

    onbgf_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_words_due  (words_due)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Result-side back-pressure, re-rolled every falling edge.
    always @(negedge i_clk) begin
        res_if.ready = ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: worst legal run is well under a fifth of this.
    initial begin
        #100ms;
        $display("onb_gf2m_arithmetic_unit regression: fail");
        $finish;
    end

    // One command transfer; valid stays high into the next call unless a gap is rolled.
    task automatic issue(input logic [2:0] op, input logic [1:0] idx, input logic [63:0] val);
        while ($urandom_range(99) < idle_pct) begin
            cmd_if.valid = 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid      = 1'b1;
        cmd_if.opcode     = op;
        cmd_if.word_index = idx;
        cmd_if.word_value = val;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic drain();
        cmd_if.valid = 1'b0;
        while (words_due != 0) @(negedge i_clk);
    endtask

    // Operand word with a bias toward corner values.
    function automatic logic [63:0] pick_word();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // A short run of loads and then one command: an operation or a spare opcode.
    task automatic random_sequence();
        int n;
        int r;
        n = $urandom_range(4);
        for (int k = 0; k < n; k++) begin
            issue($urandom_range(1) ? OP_LOAD_B : OP_LOAD_A, 2'($urandom_range(3)),
                  pick_word());
        end
        r = $urandom_range(99);
        if (r < 4) begin
            // Exponent kept sparse so a power costs only a handful of multiplies.
            for (int k = 0; k < WORD_COUNT; k++) begin
                issue(OP_LOAD_B, 2'(k), $urandom_range(2) == 0 ?
                      (64'd1 << $urandom_range(63)) | (64'd1 << $urandom_range(63)) : '0);
            end
            issue(OP_POW, 2'($urandom_range(3)), {$urandom, $urandom});
        end else if (r < 8) begin
            issue($urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6, 2'($urandom_range(3)),
                  {$urandom, $urandom});
        end else if (r < 36) begin
            issue(OP_ADD, 2'($urandom_range(3)), {$urandom, $urandom});
        end else if (r < 70) begin
            issue(OP_MUL, 2'($urandom_range(3)), {$urandom, $urandom});
        end else begin
            issue(OP_SQR, 2'($urandom_range(3)), {$urandom, $urandom});
        end
    endtask

    initial begin
        idle_pct          = 0;
        stall_pct         = 0;
        sent              = 0;
        i_rst_n           = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.opcode     = OP_LOAD_A;
        cmd_if.word_index = '0;
        cmd_if.word_value = '0;
        res_if.ready      = 1'b1;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset operands, all-ones A (top word over-wide), patterned B.
        issue(OP_ADD, 2'd0, '0);
        for (int k = 0; k < WORD_COUNT; k++) issue(OP_LOAD_A, 2'(k), '1);
        for (int k = 0; k < WORD_COUNT; k++)
            issue(OP_LOAD_B, 2'(k), k[0] ? 64'h5555_5555_5555_5555 : 64'hAAAA_AAAA_AAAA_AAAA);
        issue(OP_ADD, 2'd3, '1);
        issue(OP_MUL, 2'd0, '0);
        issue(OP_SQR, 2'd1, '0);
        issue(OP_SPARE_6, 2'd2, '1);
        issue(OP_SPARE_7, 2'd3, '0);
        issue(OP_LOAD_A, 2'd0, 64'd1);
        for (int k = 1; k < WORD_COUNT; k++) issue(OP_LOAD_A, 2'(k), '0);
        issue(OP_MUL, 2'd0, '0);
        issue(OP_SQR, 2'd0, '0);
        issue(OP_POW, 2'd0, '0);
        // Pause until the unit is fully drained before going random.
        drain();

        // Random phases: free-running, idle sender, stalling receiver, both.
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1) ? 78 : (ph == 3) ? 35 : 0;
            stall_pct = (ph == 2) ? 78 : (ph == 3) ? 35 : 0;
            while (sent < 20 + 72 * (ph + 1)) random_sequence();
            drain();
        end

        stall_pct = 0;
        repeat (300) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("onb_gf2m_arithmetic_unit regression: pass");
        end else begin
            $display("onb_gf2m_arithmetic_unit regression: fail");
        end
        $finish;
    end
endmodule
